>>> hw/rtl/display_list_line_fetcher_unit_defines.svh
// Assertion macros for the display list line fetcher.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef DISPLAY_LIST_LINE_FETCHER_UNIT_DEFINES_SVH
`define DISPLAY_LIST_LINE_FETCHER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLLF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DLLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dllf_pkg.sv
// Shared types and constants for the display list line fetcher.
// No dependencies; every module file imports this package.
package dllf_pkg;

    localparam int unsigned LINES_PER_FRAME = 27;
    localparam int unsigned LINE_W          = 5;
    localparam int unsigned ADDR_W          = 14;

    localparam logic [ADDR_W-1:0] TEXT_BASE   = 14'h2000;
    localparam logic [ADDR_W-1:0] TEXT_END    = 14'h2C00;
    localparam logic [7:0]        END_OF_LINE = 8'h7F;
    localparam logic [7:0]        COL_MAX     = 8'hFF;
    localparam logic [LINE_W-1:0] SKIP_60HZ   = 5'd2;
    localparam logic [LINE_W-1:0] SKIP_50HZ   = 5'd5;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_DELIVER = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_COLUMN_LIMIT = 1'b0;
    localparam logic REG_RATE_50HZ    = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TEXT   = 2'd1,
        PH_PTR_HI = 2'd2,
        PH_PTR_LO = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] column_limit;
        logic       rate_50hz;
    } t_cfg;

    typedef struct packed {
        logic              fetch_valid;
        logic [ADDR_W-1:0] fetch_address;
        logic              draw_valid;
        logic [7:0]        draw_column;
        logic [LINE_W-1:0] draw_row;
        logic [7:0]        draw_char;
        logic              frame_done;
    } t_result;

endpackage

>>> hw/rtl/display_list_line_fetcher_unit.sv
// Top level of the display list line fetcher: input register, walker, result register.
// Depends on dllf_pkg, dllf_cfg, dllf_walker and the assertion macro header.
//
// One fetched byte is taken per transaction and gives exactly one result. A new
// transaction is accepted in every cycle while results are taken. It is held in
// the input register, then passes through the walker's step logic into the
// result register once that register is free or drains. The walker's state
// feedback closes through its state registers, which sets the rate at one byte
// per cycle while results are taken. The user must write configuration over the
// APB-style port while no frame is being walked; the block does not enforce it.
`include "display_list_line_fetcher_unit_defines.svh"

module display_list_line_fetcher_unit import dllf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [7:0]        i_mem_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_fetch_valid,
    output logic [ADDR_W-1:0] o_fetch_address,
    output logic              o_draw_valid,
    output logic [7:0]        o_draw_column,
    output logic [LINE_W-1:0] o_draw_row,
    output logic [7:0]        o_draw_char,
    output logic              o_frame_done
);

    t_cfg       cfg;
    t_result    step_result;
    t_result    r_result;
    logic       r_in_valid;
    logic       r_op;
    logic [7:0] r_mem_byte;
    logic       r_out_valid;
    logic       advance;

    // The held transaction moves on when the result register is free or drains.
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    dllf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dllf_walker u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_op       (r_op),
        .i_mem_byte (r_mem_byte),
        .i_cfg      (cfg),
        .o_result   (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid & o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid & o_in_ready) begin
            r_op       <= i_op;
            r_mem_byte <= i_mem_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fetch_valid   = r_result.fetch_valid;
    assign o_fetch_address = r_result.fetch_address;
    assign o_draw_valid    = r_result.draw_valid;
    assign o_draw_column   = r_result.draw_column;
    assign o_draw_row      = r_result.draw_row;
    assign o_draw_char     = r_result.draw_char;
    assign o_frame_done    = r_result.frame_done;

    `DLLF_ASSERT_SAME(a_done_stops_fetch, o_out_valid && o_frame_done, !o_fetch_valid, "frame ended but a fetch is still requested")
    `DLLF_ASSERT_SAME(a_row_in_range, o_out_valid && o_draw_valid, o_draw_row < LINE_W'(LINES_PER_FRAME - 2), "drawn row beyond the last screen row")
    `DLLF_ASSERT_NEXT(a_step_gives_result, advance, o_out_valid, "a stepped transaction produced no result")

endmodule

>>> hw/rtl/dllf_cfg.sv
// APB-style configuration registers: column limit and 50 Hz select.
// Depends on dllf_pkg for the register indices and the t_cfg type.
module dllf_cfg import dllf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_column_limit;
    logic       r_rate_50hz;
    logic       wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_limit <= 8'd80;
            r_rate_50hz    <= 1'b0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_COLUMN_LIMIT: r_column_limit <= pwdata[7:0];
                REG_RATE_50HZ:    r_rate_50hz    <= pwdata[0];
                default:          r_rate_50hz    <= r_rate_50hz;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_COLUMN_LIMIT: prdata = {24'd0, r_column_limit};
            REG_RATE_50HZ:    prdata = {31'd0, r_rate_50hz};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.column_limit = r_column_limit;
    assign o_cfg.rate_50hz    = r_rate_50hz;

endmodule

>>> hw/rtl/dllf_walker.sv
// Display list walker: the fetch state and the single-pass step logic for one byte.
// Depends on dllf_pkg for the phase type, the result struct and the constants.
module dllf_walker import dllf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_op,
    input  logic [7:0] i_mem_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase              r_phase, n_phase;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [7:0]          r_col, n_col;
    logic [3:0]          r_ptr_hi, n_ptr_hi;
    logic                n_done;
    logic [LINE_W-1:0]   skip;

    assign skip = i_cfg.rate_50hz ? SKIP_50HZ : SKIP_60HZ;

    // Next state. A line can end twice in one step: once on its pointer and once
    // more when that pointer lands outside the text area.
    always_comb begin
        logic [LINE_W:0] line_inc;
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_line   = r_line;
        n_col    = r_col;
        n_ptr_hi = r_ptr_hi;
        n_done   = 1'b0;
        line_inc = '0;
        if (i_op == OP_START) begin
            n_phase  = PH_TEXT;
            n_addr   = TEXT_BASE;
            n_line   = '0;
            n_col    = '0;
            n_ptr_hi = '0;
        end else begin
            case (r_phase)
                PH_TEXT: begin
                    if (i_mem_byte == END_OF_LINE) begin
                        n_phase = PH_PTR_HI;
                    end else if (r_col != COL_MAX) begin
                        n_col = r_col + 8'd1;
                    end
                    n_addr = r_addr + 14'd1;
                end
                PH_PTR_HI: begin
                    n_ptr_hi = i_mem_byte[3:0];
                    n_addr   = r_addr + 14'd1;
                    n_phase  = PH_PTR_LO;
                end
                PH_PTR_LO: begin
                    n_addr   = {2'b10, r_ptr_hi, i_mem_byte};
                    n_col    = '0;
                    line_inc = {1'b0, r_line} + 6'd1;
                    n_line   = line_inc[LINE_W-1:0];
                    if (line_inc >= (LINE_W+1)'(LINES_PER_FRAME)) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = PH_TEXT;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        if ((n_phase == PH_TEXT) &&
            ((n_addr < TEXT_BASE) || (n_addr >= TEXT_END) || (n_col > i_cfg.column_limit))) begin
            n_addr   = TEXT_BASE;
            n_col    = '0;
            line_inc = {1'b0, n_line} + 6'd1;
            n_line   = line_inc[LINE_W-1:0];
            if (line_inc >= (LINE_W+1)'(LINES_PER_FRAME)) begin
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end
        end
    end

    // Result of this step.
    always_comb begin
        o_result               = '0;
        o_result.fetch_valid   = (n_phase != PH_IDLE);
        o_result.fetch_address = (n_phase != PH_IDLE) ? n_addr : '0;
        o_result.frame_done    = n_done;
        if ((i_op == OP_DELIVER) && (r_phase == PH_TEXT) &&
            (i_mem_byte != END_OF_LINE) && (r_line >= skip)) begin
            o_result.draw_valid  = 1'b1;
            o_result.draw_column = r_col;
            o_result.draw_row    = r_line - skip;
            o_result.draw_char   = i_mem_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_addr   <= TEXT_BASE;
            r_line   <= '0;
            r_col    <= '0;
            r_ptr_hi <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_addr   <= n_addr;
            r_line   <= n_line;
            r_col    <= n_col;
            r_ptr_hi <= n_ptr_hi;
        end
    end

endmodule
